>>> hdl/sfcm_pkg.sv
// ----------------------------------------------------------------------------
// sfcm_pkg - shared types and constants for the signed floor/ceil/mod/gcd/lcm unit
// Request and response payloads, command and status codes, overflow limits.
// ----------------------------------------------------------------------------
package sfcm_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  // Command codes
  localparam logic [2:0] CMD_FLOOR = 3'd0;
  localparam logic [2:0] CMD_CEIL  = 3'd1;
  localparam logic [2:0] CMD_MOD   = 3'd2;
  localparam logic [2:0] CMD_GCD   = 3'd3;
  localparam logic [2:0] CMD_LCM   = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // Largest result magnitude for a positive and for a negative result
  localparam logic [DATA_WIDTH:0] LIM_POS = {2'b00, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH:0] LIM_NEG = {2'b01, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [2:0]                   cmd;
    logic signed [DATA_WIDTH-1:0] operand_a;
    logic signed [DATA_WIDTH-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic [1:0]                   status;
  } rsp_t;

endpackage

>>> hdl/sfcm_div.sv
// ----------------------------------------------------------------------------
// sfcm_div - iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses after the last bit.
// ----------------------------------------------------------------------------
module sfcm_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [sfcm_pkg::DATA_WIDTH-1:0]  dividend,
  input  logic [sfcm_pkg::DATA_WIDTH-1:0]  divisor,
  output logic                             done,
  output logic [sfcm_pkg::DATA_WIDTH-1:0]  quotient,
  output logic [sfcm_pkg::DATA_WIDTH-1:0]  remainder
);

  logic                             active;
  logic [sfcm_pkg::CNT_W-1:0]       cnt;
  logic [sfcm_pkg::DATA_WIDTH-1:0]  quo;
  logic [sfcm_pkg::DATA_WIDTH-1:0]  rem;
  logic [sfcm_pkg::DATA_WIDTH-1:0]  dvs;
  logic [sfcm_pkg::DATA_WIDTH:0]    shifted;
  logic [sfcm_pkg::DATA_WIDTH:0]    diff;

  // Trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    shifted = {rem, quo[sfcm_pkg::DATA_WIDTH-1]};
    diff    = shifted - {1'b0, dvs};
  end

  // Control: count down the quotient bits while active
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= active && (cnt == '0);
      if (start) begin
        active <= 1'b1;
        cnt    <= sfcm_pkg::CNT_W'(sfcm_pkg::DATA_WIDTH - 1);
      end else if (active) begin
        if (cnt == '0) begin
          active <= 1'b0;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Datapath: shift in one dividend bit, keep the difference if it did not borrow
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (active) begin
      if (!diff[sfcm_pkg::DATA_WIDTH]) begin
        rem <= diff[sfcm_pkg::DATA_WIDTH-1:0];
        quo <= {quo[sfcm_pkg::DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem <= shifted[sfcm_pkg::DATA_WIDTH-1:0];
        quo <= {quo[sfcm_pkg::DATA_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

  // A new division is started only while the unit is free
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !active)
    else $error("divider restarted while busy");

  // Completion follows an active run
  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(active))
    else $error("divider done without a run");

  // Remainder is reduced below a nonzero divisor
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (done && dvs != '0) |-> (rem < dvs))
    else $error("divider remainder not below divisor");

endmodule

>>> hdl/signed_floor_ceil_mod_gcd_lcm_unit.sv
// ----------------------------------------------------------------------------
// signed_floor_ceil_mod_gcd_lcm_unit - signed integer floor/ceil/mod/gcd/lcm
// Sequencer around one shared iterative divider and one registered multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall/req) carries a command and two signed
//   operands; response channel (rsp_valid/rsp_stall/rsp) returns one value and
//   one status per request, in order.
//   The block takes one request at a time: req_stall is high from acceptance
//   until the result has been moved into the response register. A result that
//   waits on a stalled receiver does not block the next request.
// Sequence, from acceptance to response valid:
//   floor/ceil/mod: one division.
//   gcd: one division for each of n Euclid steps.
//   lcm: the gcd steps, then one more division and a multiply.
//   Division by zero and unknown commands answer without the divider, as
//   does lcm of two zeros.
// The divider is bit-serial, one quotient bit per cycle, and every
// division step of every command shares it.
// Reset: clears the sequencer and the response valid; no request is lost
//   except one in flight. While rsp_stall is high the response holds steady.
// ----------------------------------------------------------------------------
module signed_floor_ceil_mod_gcd_lcm_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  sfcm_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output sfcm_pkg::rsp_t  rsp
);

  localparam int W = sfcm_pkg::DATA_WIDTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_DIVW = 3'd2;
  localparam logic [2:0] S_GCD  = 3'd3;
  localparam logic [2:0] S_GCDW = 3'd4;
  localparam logic [2:0] S_LCMW = 3'd5;
  localparam logic [2:0] S_MULF = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]     state;
  logic [2:0]     cmd;
  logic [W-1:0]   a_r;
  logic [W-1:0]   b_r;
  logic [W-1:0]   x;
  logic [W-1:0]   y;
  logic [2*W-1:0] prod;
  logic [W-1:0]   val;
  logic [1:0]     st;

  logic           dv_start;
  logic [W-1:0]   dv_n;
  logic [W-1:0]   dv_d;
  logic           dv_done;
  logic [W-1:0]   dv_q;
  logic [W-1:0]   dv_r;

  logic [W-1:0]   ma;
  logic [W-1:0]   mb;
  logic [W-1:0]   mx;
  logic [W-1:0]   my;
  logic           sgn_diff;
  logic           q_neg;
  logic           q_adj;
  logic [W:0]     q_adjd;
  logic           q_ovf;
  logic [W-1:0]   q_val;
  logic [W-1:0]   r_fold;
  logic [W-1:0]   fm_val;
  logic           l_neg;
  logic           l_ovf;
  logic [W-1:0]   l_val;
  logic           rsp_load;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  // Operand magnitudes
  always_comb begin
    ma = mag(a_r);
    mb = mag(b_r);
    mx = mag(x);
    my = mag(y);
  end

  // Floored or ceiling quotient from the divider result, signs from x and y
  always_comb begin
    sgn_diff = x[W-1] != y[W-1];
    q_neg    = sgn_diff && (x != '0);
    q_adj    = (q_neg ? (cmd != sfcm_pkg::CMD_CEIL) : (cmd == sfcm_pkg::CMD_CEIL))
               && (dv_r != '0);
    q_adjd   = {1'b0, dv_q} + {{W{1'b0}}, q_adj};
    q_ovf    = q_adjd > (q_neg ? sfcm_pkg::LIM_NEG : sfcm_pkg::LIM_POS);
    q_val    = q_neg ? (~q_adjd[W-1:0] + 1'b1) : q_adjd[W-1:0];
  end

  // Floored modulo of x by y: takes the divisor's sign
  always_comb begin
    r_fold = sgn_diff ? (my - dv_r) : dv_r;
    if (dv_r == '0) begin
      fm_val = '0;
    end else begin
      fm_val = y[W-1] ? (~r_fold + 1'b1) : r_fold;
    end
  end

  // Least common multiple from the registered product
  always_comb begin
    l_neg = a_r[W-1] ^ x[W-1] ^ b_r[W-1];
    l_ovf = prod > (2*W)'(l_neg ? sfcm_pkg::LIM_NEG : sfcm_pkg::LIM_POS);
    l_val = l_neg ? (~prod[W-1:0] + 1'b1) : prod[W-1:0];
  end

  // Divider launch: Euclid and plain divisions use |x|/|y|, lcm uses |a|/|gcd|
  always_comb begin
    dv_start = 1'b0;
    dv_n     = mx;
    dv_d     = my;
    case (state)
      S_DISP: begin
        dv_start = (cmd == sfcm_pkg::CMD_FLOOR || cmd == sfcm_pkg::CMD_CEIL ||
                    cmd == sfcm_pkg::CMD_MOD) && (y != '0);
      end
      S_GCD: begin
        if (y != '0) begin
          dv_start = 1'b1;
        end else if (cmd == sfcm_pkg::CMD_LCM && x != '0) begin
          dv_start = 1'b1;
          dv_n     = ma;
          dv_d     = mx;
        end
      end
      default: begin
        dv_start = 1'b0;
      end
    endcase
  end

  sfcm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (dv_start),
    .dividend  (dv_n),
    .divisor   (dv_d),
    .done      (dv_done),
    .quotient  (dv_q),
    .remainder (dv_r)
  );

  assign req_stall = (state != S_IDLE);
  assign rsp_load  = (state == S_OUT) && (!rsp_valid || !rsp_stall);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_DISP;
          end
        end
        S_DISP: begin
          if (cmd == sfcm_pkg::CMD_GCD || cmd == sfcm_pkg::CMD_LCM) begin
            state <= S_GCD;
          end else if (dv_start) begin
            state <= S_DIVW;
          end else begin
            state <= S_OUT;
          end
        end
        S_DIVW: begin
          if (dv_done) begin
            state <= S_OUT;
          end
        end
        S_GCD: begin
          if (y != '0) begin
            state <= S_GCDW;
          end else if (dv_start) begin
            state <= S_LCMW;
          end else begin
            state <= S_OUT;
          end
        end
        S_GCDW: begin
          if (dv_done) begin
            state <= S_GCD;
          end
        end
        S_LCMW: begin
          if (dv_done) begin
            state <= S_MULF;
          end
        end
        S_MULF: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cmd <= req.cmd;
        a_r <= req.operand_a;
        b_r <= req.operand_b;
        x   <= req.operand_a;
        y   <= req.operand_b;
        val <= '0;
        st  <= sfcm_pkg::ST_OK;
      end
      S_DISP: begin
        if (cmd == sfcm_pkg::CMD_GCD || cmd == sfcm_pkg::CMD_LCM) begin
          // order the pair so the signed-larger comes first
          if ($signed(x) < $signed(y)) begin
            x <= y;
            y <= x;
          end
        end else if ((cmd == sfcm_pkg::CMD_FLOOR || cmd == sfcm_pkg::CMD_CEIL ||
                      cmd == sfcm_pkg::CMD_MOD) && y == '0) begin
          st <= sfcm_pkg::ST_DIVZ;
        end
      end
      S_DIVW: begin
        if (dv_done) begin
          if (cmd == sfcm_pkg::CMD_MOD) begin
            val <= fm_val;
          end else begin
            val <= q_val;
            if (q_ovf) begin
              st <= sfcm_pkg::ST_OVF;
            end
          end
        end
      end
      S_GCD: begin
        if (y == '0) begin
          if (cmd == sfcm_pkg::CMD_GCD) begin
            val <= x;
          end else if (x == '0) begin
            st <= sfcm_pkg::ST_DIVZ;
          end
        end
      end
      S_GCDW: begin
        // advance one Euclid step
        if (dv_done) begin
          x <= y;
          y <= fm_val;
        end
      end
      S_LCMW: begin
        if (dv_done) begin
          prod <= dv_q * mb;
        end
      end
      S_MULF: begin
        val <= l_val;
        if (l_ovf) begin
          st <= sfcm_pkg::ST_OVF;
        end
      end
      default: begin
        val <= val;
      end
    endcase
  end

  // Response register: load when free, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.value  <= (st == sfcm_pkg::ST_DIVZ) ? '0 : val;
      rsp.status <= st;
    end
  end

  // A divide-by-zero response always carries a zero value
  a_divz_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == sfcm_pkg::ST_DIVZ) |-> (rsp.value == '0))
    else $error("divide by zero with nonzero value");

  // An accepted request puts the sequencer to work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == S_DISP))
    else $error("request accepted but sequencer idle");

  // Divider completions arrive only while a state waits for them
  a_done_waited: assert property (@(posedge clk) disable iff (rst)
    dv_done |-> (state == S_DIVW || state == S_GCDW || state == S_LCMW))
    else $error("divider finished with nobody waiting");

endmodule

>>> sim/signed_floor_ceil_mod_gcd_lcm_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_floor_ceil_mod_gcd_lcm_unit_tb - self-checking bench for the signed unit
// Sends corner-case requests, then a long random mix, through the request
// channel. Each accepted request is answered in place by a behavioral model
// of floor/ceil division, floored modulo, gcd and lcm. Responses are checked
// in order while both channels idle at random.
// ----------------------------------------------------------------------------
module signed_floor_ceil_mod_gcd_lcm_unit_tb;

  localparam int DW           = sfcm_pkg::DATA_WIDTH;
  localparam int RANDOM_OPS   = 1050;
  localparam int IDLE_PCT     = 14;
  localparam int CALM_FIRST   = 500;
  localparam int CALM_LAST    = 700;
  localparam int HANG_LIMIT   = 20000;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_REPORTS  = 10;

  // Codes the unit answers with a zero result
  localparam logic [2:0] CMD_UNDEF_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNDEF_LAST  = 3'd7;

  localparam logic signed [DW-1:0] MOST_NEG   = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] MOST_POS   = {1'b0, {(DW-1){1'b1}}};
  localparam logic [63:0]          HALF_RANGE = 64'd1 << (DW - 1);

  // Consecutive Fibonacci numbers give the longest Euclid chain
  localparam int FIB_45 = 1134903170;
  localparam int FIB_46 = 1836311903;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_stall;
  sfcm_pkg::req_t req       = '0;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  sfcm_pkg::rsp_t rsp;

  sfcm_pkg::req_t ops_to_send[$];
  sfcm_pkg::rsp_t answers_due[$];
  sfcm_pkg::rsp_t oldest_answer;
  int   op_total       = 0;
  int   ops_taken      = 0;
  int   answers_seen   = 0;
  int   mismatches     = 0;
  int   quiet_cycles   = 0;
  logic req_taken_last = 1'b0;
  logic calm;

  // No idling on either side during one stretch of the run
  assign calm = (ops_taken >= CALM_FIRST) && (ops_taken < CALM_LAST);

  signed_floor_ceil_mod_gcd_lcm_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    return v[63] ? -v : v;
  endfunction

  // Floor or ceiling quotient on sign and magnitude; divisor nonzero
  function automatic logic signed [63:0] div_rounded(logic signed [63:0] a,
                                                     logic signed [63:0] b,
                                                     logic up, output logic too_big);
    logic [63:0] ma, mb, q, r;
    logic        neg;
    ma  = mag64(a);
    mb  = mag64(b);
    q   = ma / mb;
    r   = ma % mb;
    neg = (a[63] != b[63]) && (ma != 0);
    // round the magnitude away from zero when the rounding direction demands it
    if (r != 0 && neg != up) q = q + 1;
    too_big = q > (neg ? HALF_RANGE : HALF_RANGE - 1);
    return neg ? -q : q;
  endfunction

  // Remainder carrying the divisor's sign; divisor nonzero
  function automatic logic signed [63:0] mod_floored(logic signed [63:0] a,
                                                     logic signed [63:0] b);
    logic [63:0] ma, mb, r;
    ma = mag64(a);
    mb = mag64(b);
    r  = ma % mb;
    if (r == 0) return '0;
    if (a[63] != b[63]) r = mb - r;
    return b[63] ? -r : r;
  endfunction

  // Euclid with floored modulo, larger operand first; may end negative
  function automatic logic signed [63:0] euclid(logic signed [63:0] a,
                                                logic signed [63:0] b);
    logic signed [63:0] x, y, t;
    x = a;
    y = b;
    if (x == 0) return y;
    if (y == 0) return x;
    if (x < y) begin
      t = x;
      x = y;
      y = t;
    end
    while (y != 0) begin
      t = mod_floored(x, y);
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic sfcm_pkg::rsp_t compute_answer(sfcm_pkg::req_t r);
    logic signed [63:0] a, b, v, g;
    logic [63:0]        mq, mb, lim;
    logic [1:0]         st;
    logic               neg, too_big;
    sfcm_pkg::rsp_t     res;
    a       = {{(64-DW){r.operand_a[DW-1]}}, r.operand_a};
    b       = {{(64-DW){r.operand_b[DW-1]}}, r.operand_b};
    v       = '0;
    st      = sfcm_pkg::ST_OK;
    too_big = 1'b0;
    case (r.cmd)
      sfcm_pkg::CMD_FLOOR, sfcm_pkg::CMD_CEIL: begin
        if (b == 0) begin
          st = sfcm_pkg::ST_DIVZ;
        end else begin
          v = div_rounded(a, b, r.cmd == sfcm_pkg::CMD_CEIL, too_big);
          if (too_big) st = sfcm_pkg::ST_OVF;
        end
      end
      sfcm_pkg::CMD_MOD: begin
        if (b == 0) st = sfcm_pkg::ST_DIVZ;
        else v = mod_floored(a, b);
      end
      sfcm_pkg::CMD_GCD: begin
        v = euclid(a, b);
      end
      sfcm_pkg::CMD_LCM: begin
        g = euclid(a, b);
        if (g == 0) begin
          st = sfcm_pkg::ST_DIVZ;
        end else begin
          // exact product over the gcd, sign from all three signs
          mq  = mag64(a) / mag64(g);
          mb  = mag64(b);
          neg = (a[63] != g[63]) != b[63];
          lim = neg ? HALF_RANGE : HALF_RANGE - 1;
          if (mq != 0 && mb > lim / mq) st = sfcm_pkg::ST_OVF;
          v = neg ? -(mq * mb) : mq * mb;
        end
      end
      default: ;
    endcase
    if (st == sfcm_pkg::ST_DIVZ) v = '0;
    res.value  = v[DW-1:0];
    res.status = st;
    return res;
  endfunction

  // Operand mix: zero, extremes, small values, powers of two, full range
  function automatic logic signed [DW-1:0] pick_operand();
    logic signed [DW-1:0] pick;
    int                   s;
    case ($urandom_range(0, 9))
      0: pick = '0;
      1: begin
        case ($urandom_range(0, 3))
          0:       pick = MOST_NEG;
          1:       pick = MOST_POS;
          2:       pick = -1;
          default: pick = 1;
        endcase
      end
      2, 3: begin
        s    = $urandom_range(0, 40);
        pick = s - 20;
      end
      4: begin
        s    = 1 << $urandom_range(0, DW - 2);
        pick = $urandom_range(0, 1) ? -s : s;
      end
      default: pick = $urandom;
    endcase
    return pick;
  endfunction

  task automatic queue_op(input logic [2:0] c, input logic signed [DW-1:0] a,
                          input logic signed [DW-1:0] b);
    sfcm_pkg::req_t r;
    r.cmd       = c;
    r.operand_a = a;
    r.operand_b = b;
    ops_to_send.push_back(r);
  endtask

  initial begin
    forever #6 clk = ~clk;
  end

  // Drive requests at the falling edge; hold each one until it is taken
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken_last) begin
      if (ops_to_send.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        req       <= ops_to_send.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Stall the response channel at random
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Predict on each accepted request, check each accepted response in order
  always @(posedge clk) begin
    if (rst) begin
      req_taken_last <= 1'b0;
    end else begin
      req_taken_last <= req_valid && !req_stall;
      if (req_valid && !req_stall) begin
        answers_due.push_back(compute_answer(req));
        ops_taken <= ops_taken + 1;
      end
      if (rsp_valid && !rsp_stall) begin
        answers_seen <= answers_seen + 1;
        if (answers_due.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= MAX_REPORTS)
            $display("response %0d with none pending: value %0d status %0d",
                     answers_seen, rsp.value, rsp.status);
        end else begin
          oldest_answer = answers_due.pop_front();
          if (rsp.value !== oldest_answer.value || rsp.status !== oldest_answer.status) begin
            mismatches = mismatches + 1;
            if (mismatches <= MAX_REPORTS)
              $display("response %0d: expected value %0d status %0d, got value %0d status %0d",
                       answers_seen, oldest_answer.value, oldest_answer.status,
                       rsp.value, rsp.status);
          end
        end
      end
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < HANG_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("** signed_floor_ceil_mod_gcd_lcm_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [2:0] c;
    int         k, m, n;

    // Corner cases: rounding by sign, quotient overflow, divide by zero
    queue_op(sfcm_pkg::CMD_FLOOR, -7, 2);
    queue_op(sfcm_pkg::CMD_FLOOR, MOST_NEG, -1);
    queue_op(sfcm_pkg::CMD_FLOOR, MOST_POS, MOST_NEG);
    queue_op(sfcm_pkg::CMD_FLOOR, 5, 0);
    queue_op(sfcm_pkg::CMD_CEIL, 7, 2);
    queue_op(sfcm_pkg::CMD_CEIL, -7, 2);
    queue_op(sfcm_pkg::CMD_CEIL, MOST_NEG, -1);
    queue_op(sfcm_pkg::CMD_CEIL, 0, -3);
    queue_op(sfcm_pkg::CMD_MOD, -7, 3);
    queue_op(sfcm_pkg::CMD_MOD, 7, -3);
    queue_op(sfcm_pkg::CMD_MOD, MOST_NEG, -1);
    queue_op(sfcm_pkg::CMD_MOD, MOST_POS, MOST_NEG);
    queue_op(sfcm_pkg::CMD_MOD, 3, 0);
    // gcd with a zero operand, mixed signs, longest chain, most negative pair
    queue_op(sfcm_pkg::CMD_GCD, 0, -9);
    queue_op(sfcm_pkg::CMD_GCD, 12, 0);
    queue_op(sfcm_pkg::CMD_GCD, 0, 0);
    queue_op(sfcm_pkg::CMD_GCD, -12, 18);
    queue_op(sfcm_pkg::CMD_GCD, FIB_46, FIB_45);
    queue_op(sfcm_pkg::CMD_GCD, MOST_NEG, MOST_NEG);
    // lcm of two zeros, one zero, signs, overflow, most negative pair
    queue_op(sfcm_pkg::CMD_LCM, 0, 0);
    queue_op(sfcm_pkg::CMD_LCM, 0, 7);
    queue_op(sfcm_pkg::CMD_LCM, -4, 6);
    queue_op(sfcm_pkg::CMD_LCM, MOST_POS, MOST_POS - 1);
    queue_op(sfcm_pkg::CMD_LCM, MOST_NEG, MOST_NEG);
    queue_op(CMD_UNDEF_FIRST, MOST_NEG, MOST_POS);
    queue_op(CMD_UNDEF_LAST, -1, -1);

    // Random mix; gcd and lcm often get operands sharing a factor
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        c = 3'($urandom_range(CMD_UNDEF_FIRST, CMD_UNDEF_LAST));
      end else begin
        c = 3'($urandom_range(sfcm_pkg::CMD_FLOOR, sfcm_pkg::CMD_LCM));
      end
      if ((c == sfcm_pkg::CMD_GCD || c == sfcm_pkg::CMD_LCM) &&
          $urandom_range(0, 2) == 0) begin
        k = $urandom_range(1, 32767);
        m = $urandom_range(0, 65535);
        n = $urandom_range(0, 65535);
        queue_op(c, k * (m - 32768), k * (n - 32768));
      end else begin
        queue_op(c, pick_operand(), pick_operand());
      end
    end
    op_total = ops_to_send.size();

    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Wait for every request to be taken and answered, then let the unit settle
    while (ops_taken < op_total || answers_due.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("** signed_floor_ceil_mod_gcd_lcm_unit: PASSED **");
    end else begin
      $display("** signed_floor_ceil_mod_gcd_lcm_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> signed_floor_ceil_mod_gcd_lcm_unit.f
hdl/sfcm_pkg.sv
hdl/sfcm_div.sv
hdl/signed_floor_ceil_mod_gcd_lcm_unit.sv
sim/signed_floor_ceil_mod_gcd_lcm_unit_tb.sv
